// ===== hw/rtl/begcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package begcd_pkg;

  localparam int WORDS = 4;
  localparam int EW    = WORDS + 1;        // loop registers carry one guard word
  localparam int VW    = EW * 64;
  localparam int IW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = $clog2(WORDS + 2); // load position saturates at WORDS+1
  localparam int RW    = 9;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_SIGN   = 2'd2,
    ST_EXCESS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_RDW,
    S_TWOS,
    S_XEVEN,
    S_MAIN,
    S_SHL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [63:0] a_word;
    logic [63:0] b_word;
    logic        last_word;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] gcd_word;
    logic [63:0] s_word;
    logic [63:0] t_word;
    status_t     status;
    logic        last_result;
  } out_beat_t;

  typedef struct packed {
    logic          we;
    logic [IW-1:0] waddr;
    logic [127:0]  wdata;   // {a, b}
    logic [IW-1:0] raddr;
  } store_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/begcd_opstore.sv =====
`timescale 1ns / 1ps
`default_nettype none
module begcd_opstore (
  input  wire logic                  clk,
  input  wire begcd_pkg::store_req_t req,
  output logic [127:0]               rd_data_r
);
  import begcd_pkg::*;

  logic [127:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/binary_extended_gcd.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | ports                    | beat
// --------+--------------------------+------------------------------------------
// input   | start, busy, in_beat     | a/b word pair, LS first; last_word ends load
// result  | out_valid, out_beat      | gcd/s/t word + status, WORDS beats per run
//
// A load beat is taken when start is high and busy is low; non-last beats
// leave busy low. A last beat starts the run: the loaded words are read from
// the store and the final read lands, then the shared factors of two are
// stripped, x is halved until odd, and the Euclid loop halves, swaps and
// subtracts until x equals y; the shared twos are then shifted back in, and
// WORDS result beats follow on consecutive cycles. Errors skip straight to
// the result beats. Reset (rst_n low, synchronous) empties the load count;
// the result side cannot stall, so out_valid is a pure strobe.
module binary_extended_gcd (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire begcd_pkg::in_beat_t  in_beat,
  output logic                      out_valid,
  output begcd_pkg::out_beat_t      out_beat
);
  import begcd_pkg::*;

  state_t        state_r, state_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic          anz_r, anz_nxt, bnz_r, bnz_nxt, sgn_r, sgn_nxt;
  status_t       status_r, status_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] wi_r, wi_nxt;
  logic          pend_r, pend_nxt;
  logic [RW-1:0] r_r, r_nxt;
  logic [VW-1:0] al_r, al_nxt, bl_r, bl_nxt;
  logic [VW-1:0] x_r, x_nxt, xa_r, xa_nxt, xb_r, xb_nxt;
  logic [VW-1:0] y_r, y_nxt, ya_r, ya_nxt, yb_r, yb_nxt;

  store_req_t    req;
  logic [127:0]  rd_data;
  logic          accept;
  logic          excess, sign_now, anz_now, bnz_now;
  logic [2*VW-1:0] hx, hy;

  begcd_opstore u_store (
    .clk       (clk),
    .req       (req),
    .rd_data_r (rd_data)
  );

  // arithmetic halve
  function automatic logic [VW-1:0] ashr(input logic [VW-1:0] v);
    ashr = {v[VW-1], v[VW-1:1]};
  endfunction

  // halve a coefficient pair, keeping ca*A + cb*B consistent
  function automatic logic [2*VW-1:0] halve(input logic [VW-1:0] ca, input logic [VW-1:0] cb,
                                            input logic [VW-1:0] av, input logic [VW-1:0] bv);
    if (!ca[0] && !cb[0]) begin
      halve = {ashr(ca), ashr(cb)};
    end else begin
      halve = {ashr(ca + bv), ashr(cb - av)};
    end
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign hx = halve(xa_r, xb_r, al_r, bl_r);
  assign hy = halve(ya_r, yb_r, al_r, bl_r);

  // flags as they stand after this beat
  assign excess   = (pos_r >= PW'(WORDS));
  assign sign_now = sgn_r || (!excess && pos_r == PW'(WORDS - 1)
                    && (in_beat.a_word[63] || in_beat.b_word[63]));
  assign anz_now  = anz_r || (!excess && in_beat.a_word != 64'd0);
  assign bnz_now  = bnz_r || (!excess && in_beat.b_word != 64'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      anz_r    <= 1'b0;
      bnz_r    <= 1'b0;
      sgn_r    <= 1'b0;
      pend_r   <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      anz_r    <= anz_nxt;
      bnz_r    <= bnz_nxt;
      sgn_r    <= sgn_nxt;
      pend_r   <= pend_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    wi_r     <= wi_nxt;
    r_r      <= r_nxt;
    al_r     <= al_nxt;
    bl_r     <= bl_nxt;
    x_r      <= x_nxt;
    xa_r     <= xa_nxt;
    xb_r     <= xb_nxt;
    y_r      <= y_nxt;
    ya_r     <= ya_nxt;
    yb_r     <= yb_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    anz_nxt    = anz_r;
    bnz_nxt    = bnz_r;
    sgn_nxt    = sgn_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    wi_nxt     = wi_r;
    pend_nxt   = 1'b0;
    r_nxt      = r_r;
    al_nxt     = al_r;
    bl_nxt     = bl_r;
    x_nxt      = x_r;
    xa_nxt     = xa_r;
    xb_nxt     = xb_r;
    y_nxt      = y_r;
    ya_nxt     = ya_r;
    yb_nxt     = yb_r;
    req.we     = 1'b0;
    req.waddr  = pos_r[IW-1:0];
    req.wdata  = {in_beat.a_word, in_beat.b_word};
    req.raddr  = idx_r;
    out_valid  = 1'b0;
    out_beat   = '0;

    // land a word read from the operand store; unloaded words stay zero
    if (pend_r && ({{(PW-IW){1'b0}}, wi_r} < cnt_r)) begin
      al_nxt[wi_r*64 +: 64] = rd_data[127:64];
      bl_nxt[wi_r*64 +: 64] = rd_data[63:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req.we  = !excess;
          pos_nxt = excess ? PW'(WORDS + 1) : pos_r + PW'(1);
          anz_nxt = anz_now;
          bnz_nxt = bnz_now;
          sgn_nxt = sign_now;
          if (in_beat.last_word) begin
            if (excess)                 status_nxt = ST_EXCESS;
            else if (sign_now)          status_nxt = ST_SIGN;
            else if (!anz_now || !bnz_now) status_nxt = ST_ZERO;
            else                        status_nxt = ST_OK;
            cnt_nxt = pos_r + PW'(1);
            pos_nxt = '0;
            anz_nxt = 1'b0;
            bnz_nxt = 1'b0;
            sgn_nxt = 1'b0;
            idx_nxt = '0;
            al_nxt  = '0;
            bl_nxt  = '0;
            r_nxt   = '0;
            if (excess || sign_now || !anz_now || !bnz_now) state_nxt = S_EMIT;
            else                                           state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        pend_nxt = 1'b1;
        wi_nxt   = idx_r;
        idx_nxt  = idx_r + IW'(1);
        if ({{(PW-IW){1'b0}}, idx_r} + PW'(1) == cnt_r) begin
          state_nxt = S_RDW;
        end
      end
      S_RDW: begin
        idx_nxt   = '0;
        state_nxt = S_TWOS;
      end
      S_TWOS: begin
        if (!al_r[0] && !bl_r[0]) begin
          al_nxt = ashr(al_r);
          bl_nxt = ashr(bl_r);
          r_nxt  = r_r + RW'(1);
        end else begin
          x_nxt     = al_r;
          y_nxt     = bl_r;
          xa_nxt    = VW'(1);
          xb_nxt    = '0;
          ya_nxt    = '0;
          yb_nxt    = VW'(1);
          state_nxt = S_XEVEN;
        end
      end
      S_XEVEN: begin
        if (!x_r[0]) begin
          x_nxt  = ashr(x_r);
          xa_nxt = hx[2*VW-1:VW];
          xb_nxt = hx[VW-1:0];
        end else begin
          state_nxt = S_MAIN;
        end
      end
      S_MAIN: begin
        if (x_r == y_r) begin
          state_nxt = S_SHL;
        end else if (!y_r[0]) begin
          y_nxt  = ashr(y_r);
          ya_nxt = hy[2*VW-1:VW];
          yb_nxt = hy[VW-1:0];
        end else if (y_r < x_r) begin
          // values stay nonnegative, so unsigned order holds
          x_nxt  = y_r;   y_nxt  = x_r;
          xa_nxt = ya_r;  ya_nxt = xa_r;
          xb_nxt = yb_r;  yb_nxt = xb_r;
        end else begin
          y_nxt  = y_r - x_r;
          ya_nxt = ya_r - xa_r;
          yb_nxt = yb_r - xb_r;
        end
      end
      S_SHL: begin
        // restore the shared twos
        if (r_r != '0) begin
          x_nxt = {x_r[VW-2:0], 1'b0};
          r_nxt = r_r - RW'(1);
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid            = 1'b1;
        out_beat.status      = status_r;
        out_beat.last_result = (idx_r == IW'(WORDS - 1));
        if (status_r == ST_OK) begin
          out_beat.gcd_word = x_r[idx_r*64 +: 64];
          out_beat.s_word   = ya_r[idx_r*64 +: 64];
          out_beat.t_word   = yb_r[idx_r*64 +: 64];
        end
        idx_nxt = idx_r + IW'(1);
        if (idx_r == IW'(WORDS - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // results only come out of a run
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result beat outside a run");

  // error runs carry no numbers
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.status != ST_OK) |->
      (out_beat.gcd_word == 64'd0 && out_beat.s_word == 64'd0 && out_beat.t_word == 64'd0))
    else $error("error beat with nonzero payload");

  // the Euclid loop keeps x odd
  a_x_odd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAIN |-> x_r[0]) else $error("x even in main loop");

  // a run ends with its last beat
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.last_result) |=> !busy) else $error("run did not end");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import begcd_pkg::*;

  // Operand and loop widths at the block's word count.
  localparam int OPW = WORDS * 64;
  localparam int LPW = EW * 64;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  out_beat_t out_beat;

  binary_extended_gcd dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_valid(out_valid), .out_beat(out_beat)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Predictor state: operand stores and the load count.
  logic [63:0] a_store [WORDS];
  logic [63:0] b_store [WORDS];
  int          load_cnt;
  // Loop registers persist between runs; error runs report zero fields.
  logic [LPW-1:0] gcd_val, s_coef, t_coef;

  out_beat_t result_q [$];
  int        fails = 0;

  // Arithmetic shift right over the guarded width.
  function automatic logic [LPW-1:0] ashr(input logic [LPW-1:0] v);
    ashr = {v[LPW-1], v[LPW-1:1]};
  endfunction

  // Binary extended Euclid on the loaded operands.
  task automatic solve_bezout(input logic [LPW-1:0] a0, input logic [LPW-1:0] b0);
    logic [LPW-1:0] al, bl, xv, xa, xb, yv, ya, yb, tmp;
    int twos;
    al = a0; bl = b0; twos = 0;
    while (!al[0] && !bl[0]) begin
      al = al >> 1; bl = bl >> 1; twos++;
    end
    xv = al; yv = bl;
    xa = 1; xb = 0; ya = 0; yb = 1;
    while (!xv[0]) begin
      xv = xv >> 1;
      if (!xa[0] && !xb[0]) begin
        xa = ashr(xa); xb = ashr(xb);
      end else begin
        xa = ashr(xa + bl); xb = ashr(xb - al);
      end
    end
    while (xv != yv) begin
      if (!yv[0]) begin
        yv = yv >> 1;
        if (!ya[0] && !yb[0]) begin
          ya = ashr(ya); yb = ashr(yb);
        end else begin
          ya = ashr(ya + bl); yb = ashr(yb - al);
        end
      end else if (yv < xv) begin
        tmp = xv; xv = yv; yv = tmp;
        tmp = xa; xa = ya; ya = tmp;
        tmp = xb; xb = yb; yb = tmp;
      end else begin
        yv = yv - xv; ya = ya - xa; yb = yb - xb;
      end
    end
    gcd_val = xv << twos; s_coef = ya; t_coef = yb;
  endtask

  // Feed one accepted beat to the predictor; last beats queue WORDS results.
  task automatic predict_beat(input in_beat_t b);
    logic [LPW-1:0] av, bv;
    status_t st;
    out_beat_t r;
    if (load_cnt < WORDS) begin
      a_store[load_cnt] = b.a_word; b_store[load_cnt] = b.b_word; load_cnt++;
    end else load_cnt = WORDS + 1;
    if (!b.last_word) return;
    av = '0; bv = '0;
    for (int k = 0; k < WORDS; k++) begin
      av[k*64 +: 64] = a_store[k]; bv[k*64 +: 64] = b_store[k];
    end
    if (load_cnt > WORDS) st = ST_EXCESS;
    else if (av[OPW-1] || bv[OPW-1]) st = ST_SIGN;
    else if (av == 0 || bv == 0) st = ST_ZERO;
    else st = ST_OK;
    if (st == ST_OK) solve_bezout(av, bv);
    for (int k = 0; k < WORDS; k++) begin
      r.gcd_word = (st == ST_OK) ? gcd_val[k*64 +: 64] : '0;
      r.s_word = (st == ST_OK) ? s_coef[k*64 +: 64] : '0;
      r.t_word = (st == ST_OK) ? t_coef[k*64 +: 64] : '0;
      r.status = st;
      r.last_result = (k == WORDS - 1);
      result_q.push_back(r);
    end
    for (int k = 0; k < WORDS; k++) begin
      a_store[k] = '0; b_store[k] = '0;
    end
    load_cnt = 0;
  endtask

  // Result monitor: strobed beats are compared with the oldest expectation.
  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_beat);
        fails++;
      end else begin
        e = result_q.pop_front();
        if (out_beat.gcd_word !== e.gcd_word || out_beat.s_word !== e.s_word ||
            out_beat.t_word !== e.t_word || out_beat.status !== e.status ||
            out_beat.last_result !== e.last_result) begin
          $display("%0t: mismatch exp gcd=%h s=%h t=%h st=%0d l=%b", $time,
                   e.gcd_word, e.s_word, e.t_word, e.status, e.last_result);
          $display("%0t:          act gcd=%h s=%h t=%h st=%0d l=%b", $time,
                   out_beat.gcd_word, out_beat.s_word, out_beat.t_word,
                   out_beat.status, out_beat.last_result);
          fails++;
        end
      end
    end
  end

  // Directed table. Error rows carry the expected status typed in; ST_OK rows
  // go through the predictor. One row = one beat.
  typedef struct {
    logic [63:0] a, b;
    logic        last;
    status_t     want;
    logic        typed;
  } row_t;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOPB = 64'h8000_0000_0000_0000;
  localparam int NROWS = 24;
  row_t rows [NROWS] = '{
    // both operands zero after reset
    '{64'd0, 64'd0, 1'b1, ST_ZERO, 1'b1},
    // a zero, b nonzero
    '{64'd0, 64'd7, 1'b1, ST_ZERO, 1'b1},
    // trivial: gcd(1,1)
    '{64'd1, 64'd1, 1'b1, ST_OK, 1'b0},
    // shared powers of two, and one operand a power of two
    '{64'd48, 64'd36, 1'b1, ST_OK, 1'b0},
    '{64'd64, 64'd1024, 1'b1, ST_OK, 1'b0},
    '{ONES, 64'd3, 1'b1, ST_OK, 1'b0},
    // full four-word load, largest legal values
    '{ONES, ONES, 1'b0, ST_OK, 1'b0},
    '{ONES, ONES, 1'b0, ST_OK, 1'b0},
    '{ONES, 64'd5, 1'b0, ST_OK, 1'b0},
    '{64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 1'b1, ST_OK, 1'b0},
    // sign bit of the top word of b set
    '{64'd1, 64'd1, 1'b0, ST_OK, 1'b0},
    '{64'd0, 64'd0, 1'b0, ST_OK, 1'b0},
    '{64'd0, 64'd0, 1'b0, ST_OK, 1'b0},
    '{64'd3, TOPB, 1'b1, ST_SIGN, 1'b1},
    // excess words: five pairs, also zero and sign in the store
    '{64'd0, 64'd0, 1'b0, ST_OK, 1'b0},
    '{64'd0, 64'd0, 1'b0, ST_OK, 1'b0},
    '{64'd0, 64'd0, 1'b0, ST_OK, 1'b0},
    '{TOPB, 64'd0, 1'b0, ST_OK, 1'b0},
    '{64'd9, 64'd6, 1'b1, ST_EXCESS, 1'b1},
    // two-word load where a has only its upper word set
    '{64'd0, 64'd12, 1'b0, ST_OK, 1'b0},
    '{64'd1, 64'd0, 1'b1, ST_OK, 1'b0},
    // a nonzero but b zero over many words
    '{64'd5, 64'd0, 1'b0, ST_OK, 1'b0},
    '{64'd0, 64'd0, 1'b1, ST_ZERO, 1'b1},
    // equal operands
    '{64'd12345, 64'd12345, 1'b1, ST_OK, 1'b0}
  };

  // Hand one beat over: wait for busy low, hold start until taken. Start stays
  // high on return; the caller drops it before any gap.
  task automatic send_beat(input in_beat_t b);
    in_beat <= b;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_beat(b);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n != 0) start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_word(input int shape);
    logic [63:0] w;
    w = {$urandom, $urandom};
    case (shape)
      0: rand_word = w & 64'hFF;
      1: rand_word = w << $urandom_range(0, 63);
      2: rand_word = ~(64'd1 << $urandom_range(0, 63));
      default: rand_word = w;
    endcase
  endfunction

  initial begin
    in_beat_t b;
    int nw, cnt;
    logic bursty;
    for (int k = 0; k < WORDS; k++) begin
      a_store[k] = '0; b_store[k] = '0;
    end
    load_cnt = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      b.a_word = rows[i].a; b.b_word = rows[i].b; b.last_word = rows[i].last;
      send_beat(b);
      // typed-in rows: the queued status must match the table
      if (rows[i].typed && result_q[$].status != rows[i].want) begin
        $display("%0t: table row %0d exp status %0d, predicted %0d", $time, i,
                 rows[i].want, result_q[$].status);
        fails++;
      end
      if (rows[i].last) idle_gap();
    end

    // Random problems: mostly well-formed loads of 1..WORDS pairs, a few
    // with excess words, the sign bit, or zero operands.
    cnt = 0;
    while (cnt < 136) begin
      bursty = ($urandom_range(0, 3) == 0);
      nw = ($urandom_range(0, 12) == 0) ? WORDS + $urandom_range(1, 2)
                                        : $urandom_range(1, WORDS);
      for (int k = 0; k < nw; k++) begin
        b.a_word = rand_word($urandom_range(0, 5));
        b.b_word = rand_word($urandom_range(0, 5));
        if (k == WORDS - 1 && $urandom_range(0, 7) != 0) begin
          b.a_word[63] = 1'b0; b.b_word[63] = 1'b0;
        end
        if ($urandom_range(0, 15) == 0) b.a_word = '0;
        if ($urandom_range(0, 15) == 0) b.b_word = '0;
        b.last_word = (k == nw - 1);
        send_beat(b);
        cnt++;
        if (!bursty) idle_gap();
      end
      // sender holds off until the block has drained: first problem, then now and then
      if ((cnt <= nw || $urandom_range(0, 9) == 0) && result_q.size() != 0) begin
        start <= 1'b0;
        while (result_q.size() != 0) @(negedge clk);
      end
    end

    start <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fails == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
